// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file sfhpr_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SFHPR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfhpr: implication failed");

// Next-cycle implication, held off during reset.
`define SFHPR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfhpr: next-cycle implication failed");

`endif

// ----- rtl/sfhpr_pkg.sv -----
// Types, codes and constants for the sync-framed hex payload receiver.
// No dependencies.
package sfhpr_pkg;

  localparam int VALUE_W = 31;
  localparam int WIN_MAX = 16;

  typedef enum logic [1:0] {
    KIND_MODE = 2'd0,
    KIND_LEN  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_MODE  = 3'd1,
    ERR_TOO_LONG  = 3'd2,
    ERR_ZERO_LEN  = 3'd3,
    ERR_BAD_HEX   = 3'd4
  } err_e;

  // "serial sync " padded with spaces
  localparam logic [7:0] SYNC_PATTERN [WIN_MAX] = '{
    8'h73, 8'h65, 8'h72, 8'h69, 8'h61, 8'h6C, 8'h20, 8'h73,
    8'h79, 8'h6E, 8'h63, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
  };

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[2:0] + 3'd1) + 4'd8};
    end
    return r;
  endfunction

endpackage

// ----- rtl/sync_framed_hex_payload_receiver.sv -----
// Sync-framed hex payload receiver: sync hunt, mode, length and hex decode.
// Depends on sfhpr_pkg.
//
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+-----------------------------------
// in      | in        | in_valid_i / in_stall_o  | rx_byte_i
// out     | out       | out_valid_o / out_stall_i| kind_o value_o last_o error_code_o
//
// One byte per cycle sustained while no result is held up by an output stall;
// an accepted request sits in the input register and is decoded there, and its
// result loads into the result register once that register can take it. A stall
// on the output holds the result register; requests with no result keep flowing
// while it waits. Reset is asynchronous and returns the block to sync hunting
// with an empty window.
module sync_framed_hex_payload_receiver #(
  parameter int SYNC_LEN   = 12,
  parameter int MAX_DIGITS = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [sfhpr_pkg::VALUE_W-1:0]  value_o,
  output logic                           last_o,
  output logic [2:0]                     error_code_o
);

  localparam int VW = sfhpr_pkg::VALUE_W;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_MODE   = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_HEX_HI = 3'd3;
  localparam logic [2:0] PH_HEX_LO = 3'd4;

  logic          in_valid_q;
  logic [7:0]    byte_q;

  logic [2:0]    phase_q, phase_d;
  logic [7:0]    win_q [SYNC_LEN];
  logic [7:0]    win_d [SYNC_LEN];
  logic [VW-1:0] acc_q, acc_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [3:0]    hi_q, hi_d;

  logic                  res_valid;
  sfhpr_pkg::kind_e      res_kind;
  logic [VW-1:0]         res_value;
  logic                  res_last;
  sfhpr_pkg::err_e       res_err;

  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [VW-1:0] value_q;
  logic          last_q;
  logic [2:0]    err_q;

  logic          fire;
  logic [4:0]    hex;
  logic          is_digit;
  logic          match;

  assign hex      = sfhpr_pkg::hex_decode(byte_q);
  assign is_digit = (byte_q >= sfhpr_pkg::CHAR_ZERO) && (byte_q <= sfhpr_pkg::CHAR_NINE);

  // results may only be produced when the result register is free or draining
  assign fire       = in_valid_q && (!res_valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_comb begin
    phase_d   = phase_q;
    win_d     = win_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    hi_d      = hi_q;
    res_valid = 1'b0;
    res_kind  = sfhpr_pkg::KIND_MODE;
    res_value = '0;
    res_last  = 1'b0;
    res_err   = sfhpr_pkg::ERR_NONE;
    match     = 1'b1;

    unique case (phase_q)
      PH_MODE: begin
        res_valid = 1'b1;
        if (byte_q == sfhpr_pkg::CHAR_ZERO || byte_q == sfhpr_pkg::CHAR_ONE) begin
          phase_d   = PH_LEN;
          acc_d     = '0;
          cnt_d     = '0;
          res_value = VW'(byte_q == sfhpr_pkg::CHAR_ONE);
        end else begin
          phase_d  = PH_HUNT;
          acc_d    = '0;
          cnt_d    = '0;
          rem_d    = '0;
          hi_d     = '0;
          res_kind = sfhpr_pkg::KIND_ERR;
          res_err  = sfhpr_pkg::ERR_BAD_MODE;
        end
      end

      PH_LEN: begin
        if (is_digit) begin
          if (cnt_q >= 4'(MAX_DIGITS)) begin
            phase_d   = PH_HUNT;
            acc_d     = '0;
            cnt_d     = '0;
            rem_d     = '0;
            hi_d      = '0;
            res_valid = 1'b1;
            res_kind  = sfhpr_pkg::KIND_ERR;
            res_err   = sfhpr_pkg::ERR_TOO_LONG;
          end else begin
            acc_d = VW'((acc_q << 3) + (acc_q << 1) + VW'(byte_q[3:0]));
            cnt_d = cnt_q + 4'd1;
          end
        end else if (acc_q == '0) begin
          phase_d   = PH_HUNT;
          acc_d     = '0;
          cnt_d     = '0;
          rem_d     = '0;
          hi_d      = '0;
          res_valid = 1'b1;
          res_kind  = sfhpr_pkg::KIND_ERR;
          res_err   = sfhpr_pkg::ERR_ZERO_LEN;
        end else begin
          rem_d     = acc_q;
          phase_d   = PH_HEX_HI;
          cnt_d     = '0;
          res_valid = 1'b1;
          res_kind  = sfhpr_pkg::KIND_LEN;
          res_value = acc_q;
        end
      end

      PH_HEX_HI, PH_HEX_LO: begin
        if (!hex[4]) begin
          phase_d   = PH_HUNT;
          acc_d     = '0;
          cnt_d     = '0;
          rem_d     = '0;
          hi_d      = '0;
          res_valid = 1'b1;
          res_kind  = sfhpr_pkg::KIND_ERR;
          res_err   = sfhpr_pkg::ERR_BAD_HEX;
        end else if (phase_q == PH_HEX_HI) begin
          hi_d    = hex[3:0];
          phase_d = PH_HEX_LO;
        end else begin
          res_valid = 1'b1;
          res_kind  = sfhpr_pkg::KIND_DATA;
          res_value = VW'({hi_q, hex[3:0]});
          res_last  = (rem_q <= VW'(1));
          hi_d      = '0;
          if (rem_q != '0) begin
            rem_d = rem_q - VW'(1);
          end
          if (res_last) begin
            phase_d = PH_HUNT;
            acc_d   = '0;
            rem_d   = '0;
          end else begin
            phase_d = PH_HEX_HI;
          end
        end
      end

      default: begin
        phase_d = PH_HUNT;
        for (int i = 0; i < SYNC_LEN - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[SYNC_LEN-1] = byte_q;
        for (int i = 0; i < SYNC_LEN; i++) begin
          if (win_d[i] != sfhpr_pkg::SYNC_PATTERN[i]) begin
            match = 1'b0;
          end
        end
        if (match) begin
          for (int i = 0; i < SYNC_LEN; i++) begin
            win_d[i] = 8'h00;
          end
          phase_d = PH_MODE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      acc_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      hi_q    <= '0;
      for (int i = 0; i < SYNC_LEN; i++) begin
        win_q[i] <= 8'h00;
      end
    end else if (fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      hi_q    <= hi_d;
      win_q   <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      kind_q  <= res_kind;
      value_q <= res_value;
      last_q  <= res_last;
      err_q   <= res_err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign last_o       = last_q;
  assign error_code_o = err_q;

endmodule

// ----- rtl/sfhpr_checker.sv -----
// Port-level checks for the receiver, bound to the top level.
// Depends on sfhpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfhpr_port_asserts (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    kind_o,
  input logic [sfhpr_pkg::VALUE_W-1:0] value_o,
  input logic                          last_o,
  input logic [2:0]                    error_code_o
);

  logic is_err;

  assign is_err = (kind_o == sfhpr_pkg::KIND_ERR);

  `SFHPR_ASSERT_IMP(a_err_code, clk_i, rst_ni, out_valid_o && is_err,
    error_code_o != sfhpr_pkg::ERR_NONE && value_o == '0 && !last_o)
  `SFHPR_ASSERT_IMP(a_no_code, clk_i, rst_ni, out_valid_o && !is_err,
    error_code_o == sfhpr_pkg::ERR_NONE)
  `SFHPR_ASSERT_IMP(a_last_data, clk_i, rst_ni, out_valid_o && last_o,
    kind_o == sfhpr_pkg::KIND_DATA)
  `SFHPR_ASSERT_IMP(a_mode_bit, clk_i, rst_ni,
    out_valid_o && kind_o == sfhpr_pkg::KIND_MODE, value_o <= 1)
  `SFHPR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(value_o) && $stable(kind_o))

endmodule

bind sync_framed_hex_payload_receiver sfhpr_port_asserts u_sfhpr_port_asserts (.*);
